### rtl/lbsr_pkg.sv
// shared types and constants for the literal byte string replacer
`default_nettype none
package lbsr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 64;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACEMENT_MAX_DEF = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_LEN   = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SHIFT
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     keep;
        logic     used;
    } t_cell_ctrl;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_present;
        logic              out_end;
    } t_res;

endpackage
`default_nettype wire

### rtl/lbsr_text_if.sv
// input channel carrying one text byte per transfer
`default_nettype none
interface lbsr_text_if;
    logic                      valid;
    logic                      ready;
    logic [lbsr_pkg::BYTE_W-1:0] text_byte;
    logic                      text_end;

    modport source (output valid, output text_byte, output text_end, input ready);
    modport sink (input valid, input text_byte, input text_end, output ready);
endinterface
`default_nettype wire

### rtl/lbsr_res_if.sv
// output channel carrying one result byte or end marker per transfer
`default_nettype none
interface lbsr_res_if;
    logic                      valid;
    logic                      ready;
    logic [lbsr_pkg::BYTE_W-1:0] out_byte;
    logic                      byte_present;
    logic                      out_end;

    modport source (output valid, output out_byte, output byte_present, output out_end,
                    input ready);
    modport sink (input valid, input out_byte, input byte_present, input out_end,
                  output ready);
endinterface
`default_nettype wire

### rtl/lbsr_cell.sv
// one window cell: holds a byte, compares it with its pattern byte, shifts to neighbor
`default_nettype none
module lbsr_cell (
    input  wire logic                        i_clk,
    input  wire lbsr_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [lbsr_pkg::BYTE_W-1:0] i_in_byte,
    input  wire logic [lbsr_pkg::BYTE_W-1:0] i_next,
    input  wire logic [lbsr_pkg::BYTE_W-1:0] i_pat,
    output logic      [lbsr_pkg::BYTE_W-1:0] o_app,
    output logic                             o_match
);
    import lbsr_pkg::*;

    logic [BYTE_W-1:0] r_byte;

    // byte this cell holds once the incoming byte is appended
    assign o_app   = i_ctrl.keep ? r_byte : i_in_byte;
    assign o_match = !i_ctrl.used || (o_app == i_pat);

    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            OP_LOAD:  r_byte <= o_app;
            OP_SHIFT: r_byte <= i_next;
            default:  r_byte <= r_byte;
        endcase
    end

endmodule
`default_nettype wire

### rtl/lbsr_out_fifo.sv
// two-entry result queue between the sequencer and the output channel
`default_nettype none
module lbsr_out_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lbsr_pkg::t_res i_item,
    output logic               o_space,
    output logic               o_valid,
    output lbsr_pkg::t_res     o_item,
    input  wire logic          i_pop
);
    import lbsr_pkg::*;

    t_res       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/literal_byte_string_replace.sv
// Literal byte string replacer top level.
// Input channel i_text takes one text byte per transfer, text_end marks the last
// byte of a text. Output channel o_res gives result bytes; out_end marks the last
// result of a text, and a text whose final step yields nothing ends with one
// marker item with byte_present low.
// The window is a row of PATTERN_MAX cells; a byte is appended and all cells are
// compared against the pattern in the cycle of its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and the
// result queue has space. A match with a replacement of more than one byte, or the
// final byte of a text with bytes left in the window, makes the sequencer emit the
// remaining results from ST_REPL or ST_FLUSH, holding ready low meanwhile. Results are registered in the result queue.
// A two-entry result queue sits before o_res, so the input keeps being taken while
// a result waits; when the receiver stalls the queue fills and ready drops.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle;
// writing the pattern length empties the window.
// Synchronous reset clears the configuration, the sequencer, the window fill and the
// queue count; there is no clearing pass, the block takes input in the first cycle after reset.
`default_nettype none
module literal_byte_string_replace #(
    parameter int PATTERN_MAX     = lbsr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACEMENT_MAX = lbsr_pkg::REPLACEMENT_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lbsr_text_if.sink                            i_text,
    lbsr_res_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [lbsr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lbsr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lbsr_pkg::*;

    localparam int FW  = $clog2(PATTERN_MAX + 1);
    localparam int RW  = $clog2(REPLACEMENT_MAX + 1);
    localparam int RIW = (REPLACEMENT_MAX > 1) ? $clog2(REPLACEMENT_MAX) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REPL,
        ST_FLUSH
    } t_state;

    // configuration
    logic [PATTERN_MAX*BYTE_W-1:0]     r_pat_bytes;
    logic [LEN_W-1:0]                  r_pat_len;
    logic [REPLACEMENT_MAX*BYTE_W-1:0] r_rep_bytes;
    logic [LEN_W-1:0]                  r_rep_len;

    t_state         r_state, n_state;
    logic [FW-1:0]  r_fill, n_fill;
    logic [RIW-1:0] r_idx, n_idx;
    logic           r_last, n_last;

    logic [FW-1:0]  w_plen;
    logic [RW-1:0]  w_rlen;
    logic [FW-1:0]  w_fill_eff;
    logic [FW-1:0]  w_fill_nxt;
    logic           w_accept;
    logic           w_full;
    logic           w_hit;
    logic           w_space;
    logic           w_push;
    t_res           w_push_item;
    t_res           w_out_item;
    logic           w_out_valid;
    t_cell_op       w_op;

    logic [BYTE_W-1:0]      w_app   [PATTERN_MAX];
    t_cell_ctrl             w_ctrl  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] w_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_bytes <= '0;
            r_pat_len   <= '0;
            r_rep_bytes <= '0;
            r_rep_len   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAT_BYTES: r_pat_bytes <= i_cfg_data[PATTERN_MAX*BYTE_W-1:0];
                REG_PAT_LEN:   r_pat_len   <= i_cfg_data[LEN_W-1:0];
                REG_REP_BYTES: r_rep_bytes <= i_cfg_data[REPLACEMENT_MAX*BYTE_W-1:0];
                REG_REP_LEN:   r_rep_len   <= i_cfg_data[LEN_W-1:0];
                default:       r_rep_len   <= r_rep_len;
            endcase
        end
    end

    // lengths above the cell count saturate
    assign w_plen = (r_pat_len > LEN_W'(PATTERN_MAX)) ? FW'(PATTERN_MAX) : r_pat_len[FW-1:0];
    assign w_rlen = (r_rep_len > LEN_W'(REPLACEMENT_MAX)) ? RW'(REPLACEMENT_MAX)
                                                          : r_rep_len[RW-1:0];

    assign w_fill_eff = (r_fill >= w_plen) ? '0 : r_fill;
    assign w_fill_nxt = w_fill_eff + FW'(1);
    assign w_full     = (w_fill_nxt == w_plen);
    assign w_hit      = &w_match;

    assign i_text.ready = (r_state == ST_IDLE) && w_space;
    assign w_accept     = i_text.valid && i_text.ready;

    // row of window cells
    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        logic [BYTE_W-1:0] w_next;

        assign w_ctrl[k].op   = w_op;
        assign w_ctrl[k].keep = (r_state == ST_FLUSH) || (FW'(k) < w_fill_eff);
        assign w_ctrl[k].used = FW'(k) < w_plen;

        if (k == PATTERN_MAX - 1) begin : g_tail
            assign w_next = i_text.text_byte;
        end else begin : g_body
            assign w_next = w_app[k+1];
        end

        lbsr_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (w_ctrl[k]),
            .i_in_byte (i_text.text_byte),
            .i_next    (w_next),
            .i_pat     (r_pat_bytes[k*BYTE_W +: BYTE_W]),
            .o_app     (w_app[k]),
            .o_match   (w_match[k])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_idx       = r_idx;
        n_last      = r_last;
        w_push      = 1'b0;
        w_push_item = '0;
        w_op        = OP_HOLD;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (w_plen == '0) begin
                        w_push      = 1'b1;
                        w_push_item = '{out_byte: i_text.text_byte, byte_present: 1'b1,
                                        out_end: i_text.text_end};
                        n_fill      = '0;
                    end else if (w_full && w_hit) begin
                        n_fill = '0;
                        if (w_rlen != '0) begin
                            w_push      = 1'b1;
                            w_push_item = '{out_byte: r_rep_bytes[BYTE_W-1:0],
                                            byte_present: 1'b1,
                                            out_end: i_text.text_end && (w_rlen == RW'(1))};
                            if (w_rlen != RW'(1)) begin
                                n_state = ST_REPL;
                                n_idx   = RIW'(1);
                                n_last  = i_text.text_end;
                            end
                        end else if (i_text.text_end) begin
                            // empty end marker
                            w_push      = 1'b1;
                            w_push_item = '{out_byte: '0, byte_present: 1'b0, out_end: 1'b1};
                        end
                    end else if (w_full || i_text.text_end) begin
                        // oldest byte leaves the window
                        w_push      = 1'b1;
                        w_push_item = '{out_byte: w_app[0], byte_present: 1'b1,
                                        out_end: i_text.text_end && (w_fill_nxt == FW'(1))};
                        w_op        = OP_SHIFT;
                        n_fill      = w_fill_nxt - FW'(1);
                        if (i_text.text_end && (w_fill_nxt != FW'(1))) begin
                            n_state = ST_FLUSH;
                        end
                    end else begin
                        w_op   = OP_LOAD;
                        n_fill = w_fill_nxt;
                    end
                end
            end
            ST_REPL: begin
                if (w_space) begin
                    w_push      = 1'b1;
                    w_push_item = '{out_byte: r_rep_bytes[r_idx*BYTE_W +: BYTE_W],
                                    byte_present: 1'b1,
                                    out_end: r_last && (RW'(r_idx) == w_rlen - RW'(1))};
                    n_idx       = r_idx + RIW'(1);
                    if (RW'(r_idx) == w_rlen - RW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FLUSH: begin
                if (w_space) begin
                    w_push      = 1'b1;
                    w_push_item = '{out_byte: w_app[0], byte_present: 1'b1,
                                    out_end: (r_fill == FW'(1))};
                    w_op        = OP_SHIFT;
                    n_fill      = r_fill - FW'(1);
                    if (r_fill == FW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // a new pattern length empties the window
        if (i_cfg_we && (i_cfg_idx == REG_PAT_LEN)) begin
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_idx   <= n_idx;
            r_last  <= n_last;
        end
    end

    lbsr_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_space (w_space),
        .o_valid (w_out_valid),
        .o_item  (w_out_item),
        .i_pop   (o_res.valid && o_res.ready)
    );

    assign o_res.valid        = w_out_valid;
    assign o_res.out_byte     = w_out_item.out_byte;
    assign o_res.byte_present = w_out_item.byte_present;
    assign o_res.out_end      = w_out_item.out_end;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(PATTERN_MAX))
        else $error("window fill above cell count");

    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_space)
        else $error("result pushed into a full queue");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && w_push_item.out_end) |=> (r_fill == '0 && r_state == ST_IDLE))
        else $error("text end left window or sequencer busy");

    a_flush_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FLUSH) |-> (r_fill != '0))
        else $error("flush with empty window");
`endif

endmodule
`default_nettype wire
